[rtl/plra_pkg.sv]
// Package for the piecewise-linear range average block.
// Holds command and status codes, datapath widths and the one-hot state type.
// No dependencies.
package plra_pkg;

  localparam int PLRA_MAX_SAMPLES = 64;

  // Stored entry: wavelength in the low 16 bits, level above it.
  localparam int WL_W    = 16;
  localparam int LV_W    = 32;
  localparam int ENTRY_W = WL_W + LV_W;

  // Divider and accumulator widths.
  localparam int NUM_W = 52;
  localparam int DEN_W = 17;
  localparam int QUO_W = NUM_W + 1;
  localparam int SUM_W = 52;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO_WIDTH = 3'd1;
  localparam logic [2:0] ST_NO_SAMPLES = 3'd2;
  localparam logic [2:0] ST_UNSORTED   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_TAIL0   = 14'b00000000000010,
    S_TAIL1   = 14'b00000000000100,
    S_TAIL2   = 14'b00000000001000,
    S_WAIT    = 14'b00000000010000,
    S_SEG     = 14'b00000000100000,
    S_LA      = 14'b00000001000000,
    S_LA_DIV  = 14'b00000010000000,
    S_LB      = 14'b00000100000000,
    S_LB_DIV  = 14'b00001000000000,
    S_ACC_MUL = 14'b00010000000000,
    S_ACC     = 14'b00100000000000,
    S_FDIV    = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

endpackage

[rtl/plra_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module plra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/plra_div.sv]
// Bit-serial signed floor divider: one quotient bit per cycle.
// Depends on plra_pkg for operand widths.
module plra_div import plra_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] qm_r, qm_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, qm_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qm_nxt   = qm_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[NUM_W-1];
      qm_nxt   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      qm_nxt  = {qm_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    qm_r  <= qm_nxt;
  end

  // A negative dividend with a remainder rounds one further down.
  assign done = done_r;
  assign quo  = neg_r ? QUO_W'(-$signed({1'b0, qm_r}) - $signed({1'b0, |rem_r}))
                      : $signed({1'b0, qm_r});

endmodule

[rtl/piecewise_linear_range_average.sv]
// Piecewise-linear range average: clear, append and query on a stored sample curve.
// Clear, append and early-exit queries go straight to the hand-off state. A full query
// sums the tails, walks every segment, divides once for each clipped segment end (at
// most two) on the bit-serial divider, then runs the final division and hands off the item.
// Synchronous active-low reset empties the store; the sample RAM itself is not cleared.
module piecewise_linear_range_average import plra_pkg::*; #(
  parameter int MAX_SAMPLES = PLRA_MAX_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sample_wavelength[15:0], sample_level[47:16], range_start[63:48], range_end[79:64]
  input  logic [79:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // average[31:0]
  output logic [31:0] out_tdata,
  // status[2:0]
  output logic [2:0]  out_tuser
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // Input item fields.
  logic [1:0]         cmd;
  logic [WL_W-1:0]    in_wl, in_s, in_e;
  logic signed [31:0] in_lv;

  assign cmd   = in_tuser;
  assign in_wl = in_tdata[15:0];
  assign in_lv = $signed(in_tdata[47:16]);
  assign in_s  = in_tdata[63:48];
  assign in_e  = in_tdata[79:64];

  // Control and bookkeeping state.
  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               order_r, order_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               div_start_r, div_start_nxt;
  logic               out_valid_r, out_valid_nxt;

  // The ends of the curve are kept in registers so early exits need no memory read.
  logic [WL_W-1:0]    first_wl_r, first_wl_nxt, last_wl_r, last_wl_nxt;
  logic signed [31:0] first_lv_r, first_lv_nxt, last_lv_r, last_lv_nxt;

  // Query datapath.
  logic [WL_W-1:0]          s_r, s_nxt, e_r, e_nxt;
  logic [WL_W-1:0]          prev_wl_r, prev_wl_nxt, seg_wl_r, seg_wl_nxt;
  logic signed [31:0]       prev_lv_r, prev_lv_nxt, seg_lv_r, seg_lv_nxt;
  logic [WL_W-1:0]          a_r, a_nxt, b_r, b_nxt;
  logic signed [33:0]       la_r, la_nxt, lb_r, lb_nxt;
  logic signed [SUM_W-1:0]  prod_r, prod_nxt, sum_r, sum_nxt;
  logic signed [31:0]       res_avg_r, res_avg_nxt, out_avg_r, out_avg_nxt;
  logic [2:0]               res_st_r, res_st_nxt, out_st_r, out_st_nxt;

  // Memory interface.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [WL_W-1:0]    rd_wl;
  logic signed [31:0] rd_lv;

  assign rd_wl = ram_rdata[WL_W-1:0];
  assign rd_lv = $signed(ram_rdata[ENTRY_W-1:WL_W]);

  // Shared multiplier, operands picked by the sequencer state.
  logic signed [34:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [SUM_W-1:0] mul_p;

  // Shared divider.
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;
  logic signed [QUO_W-1:0] lerp_full;

  logic [WL_W-1:0] width;
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   last_idx;
  logic            at_last, full;
  logic [WL_W-1:0] seg_a, seg_b;
  logic            seg_skip;
  logic            fin_take;

  assign width    = e_r - s_r;
  assign cnt_m1   = count_r - 1'b1;
  assign last_idx = cnt_m1[AW-1:0];
  assign at_last  = idx_r == last_idx;
  assign full     = count_r == CW'(MAX_SAMPLES);

  // Segment clipped to the query range.
  assign seg_a    = (s_r > prev_wl_r) ? s_r : prev_wl_r;
  assign seg_b    = (e_r < rd_wl) ? e_r : rd_wl;
  assign seg_skip = seg_b <= seg_a;

  assign in_tready = state_r == S_IDLE;
  assign fin_take  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign ram_we    = in_tvalid && in_tready && cmd == CMD_APPEND && !full;
  assign ram_waddr = count_r[AW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TAIL0: begin
        mul_a = 35'(first_lv_r);
        mul_b = (s_r < first_wl_r) ? $signed({1'b0, first_wl_r - s_r}) : '0;
      end
      S_TAIL1: begin
        mul_a = 35'(last_lv_r);
        mul_b = (e_r > last_wl_r) ? $signed({1'b0, e_r - last_wl_r}) : '0;
      end
      S_LA: begin
        mul_a = 35'(seg_lv_r) - 35'(prev_lv_r);
        mul_b = $signed({1'b0, a_r - prev_wl_r});
      end
      S_LB: begin
        mul_a = 35'(seg_lv_r) - 35'(prev_lv_r);
        mul_b = $signed({1'b0, b_r - prev_wl_r});
      end
      S_ACC_MUL: begin
        mul_a = 35'(la_r) + 35'(lb_r);
        mul_b = $signed({1'b0, b_r - a_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The final division works on the rounded sum; interpolation on the segment slope.
  assign div_num   = (state_r == S_FDIV) ? sum_r + $signed({{(SUM_W-WL_W){1'b0}}, width})
                                         : prod_r;
  assign div_den   = (state_r == S_FDIV) ? {width, 1'b0} : {1'b0, seg_wl_r - prev_wl_r};
  assign lerp_full = QUO_W'(prev_lv_r) + div_quo;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    order_nxt     = order_r;
    idx_nxt       = idx_r;
    div_start_nxt = 1'b0;
    first_wl_nxt  = first_wl_r;
    first_lv_nxt  = first_lv_r;
    last_wl_nxt   = last_wl_r;
    last_lv_nxt   = last_lv_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    prev_wl_nxt   = prev_wl_r;
    prev_lv_nxt   = prev_lv_r;
    seg_wl_nxt    = seg_wl_r;
    seg_lv_nxt    = seg_lv_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    res_avg_nxt   = res_avg_r;
    res_st_nxt    = res_st_r;
    out_avg_nxt   = out_avg_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_avg_nxt = '0;
          res_st_nxt  = ST_OK;
          s_nxt       = in_s;
          e_nxt       = in_e;
          idx_nxt     = '0;
          state_nxt   = S_FIN;
          unique case (cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              order_nxt = 1'b1;
            end
            CMD_APPEND: begin
              if (full) begin
                res_st_nxt = ST_FULL;
              end else begin
                if (count_r == '0) begin
                  first_wl_nxt = in_wl;
                  first_lv_nxt = in_lv;
                end else if (in_wl < last_wl_r) begin
                  order_nxt = 1'b0;
                end
                last_wl_nxt = in_wl;
                last_lv_nxt = in_lv;
                count_nxt   = count_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              // Early exits, in the order the curve definition checks them.
              priority if (count_r == '0) begin
                res_st_nxt = ST_NO_SAMPLES;
              end else if (!order_r) begin
                res_st_nxt = ST_UNSORTED;
              end else if (in_e <= first_wl_r) begin
                res_avg_nxt = first_lv_r;
              end else if (in_s >= last_wl_r) begin
                res_avg_nxt = last_lv_r;
              end else if (count_r == CW'(1)) begin
                res_avg_nxt = first_lv_r;
              end else if (in_e <= in_s) begin
                res_st_nxt = ST_ZERO_WIDTH;
              end else begin
                state_nxt = S_TAIL0;
              end
            end
            default: begin
              res_st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_TAIL0: begin
        prod_nxt  = mul_p;
        state_nxt = S_TAIL1;
      end
      S_TAIL1: begin
        sum_nxt   = prod_r <<< 1;
        prod_nxt  = mul_p;
        state_nxt = S_TAIL2;
      end
      S_TAIL2: begin
        // Entry zero has been read while the tails were summed.
        sum_nxt     = sum_r + (prod_r <<< 1);
        prev_wl_nxt = rd_wl;
        prev_lv_nxt = rd_lv;
        idx_nxt     = AW'(1);
        state_nxt   = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_SEG;
      end
      S_SEG: begin
        if (seg_skip) begin
          // Segment outside the range or of zero width adds nothing.
          prev_wl_nxt = rd_wl;
          prev_lv_nxt = rd_lv;
          if (at_last) begin
            div_start_nxt = 1'b1;
            state_nxt     = S_FDIV;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_WAIT;
          end
        end else begin
          seg_wl_nxt = rd_wl;
          seg_lv_nxt = rd_lv;
          a_nxt      = seg_a;
          b_nxt      = seg_b;
          state_nxt  = S_LA;
        end
      end
      S_LA: begin
        if (a_r == prev_wl_r) begin
          la_nxt    = 34'(prev_lv_r);
          state_nxt = S_LB;
        end else begin
          prod_nxt      = mul_p;
          div_start_nxt = 1'b1;
          state_nxt     = S_LA_DIV;
        end
      end
      S_LA_DIV: begin
        if (div_done) begin
          la_nxt    = lerp_full[33:0];
          state_nxt = S_LB;
        end
      end
      S_LB: begin
        if (b_r == seg_wl_r) begin
          lb_nxt    = 34'(seg_lv_r);
          state_nxt = S_ACC_MUL;
        end else begin
          prod_nxt      = mul_p;
          div_start_nxt = 1'b1;
          state_nxt     = S_LB_DIV;
        end
      end
      S_LB_DIV: begin
        if (div_done) begin
          lb_nxt    = lerp_full[33:0];
          state_nxt = S_ACC_MUL;
        end
      end
      S_ACC_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt     = sum_r + prod_r;
        prev_wl_nxt = seg_wl_r;
        prev_lv_nxt = seg_lv_r;
        if (at_last) begin
          div_start_nxt = 1'b1;
          state_nxt     = S_FDIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          // Saturate the mean to the signed 32-bit result range.
          priority if (div_quo > QUO_W'(32'sh7FFFFFFF)) begin
            res_avg_nxt = 32'sh7FFFFFFF;
          end else if (div_quo < QUO_W'(-33'sh80000000)) begin
            res_avg_nxt = -32'sh80000000;
          end else begin
            res_avg_nxt = div_quo[31:0];
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_take) begin
          out_avg_nxt   = res_avg_r;
          out_st_nxt    = res_st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      order_r     <= 1'b1;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      order_r     <= order_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    first_wl_r <= first_wl_nxt;
    first_lv_r <= first_lv_nxt;
    last_wl_r  <= last_wl_nxt;
    last_lv_r  <= last_lv_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    prev_wl_r  <= prev_wl_nxt;
    prev_lv_r  <= prev_lv_nxt;
    seg_wl_r   <= seg_wl_nxt;
    seg_lv_r   <= seg_lv_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    res_avg_r  <= res_avg_nxt;
    res_st_r   <= res_st_nxt;
    out_avg_r  <= out_avg_nxt;
    out_st_r   <= out_st_nxt;
  end

  plra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_lv, in_wl}),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  plra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_avg_r;
  assign out_tuser  = out_st_r;

endmodule

[tb/sv/tb_piecewise_linear_range_average.sv]
// Self-checking testbench for the piecewise-linear range average block.
// Depends on plra_pkg and piecewise_linear_range_average from the RTL.
// A scoreboard class predicts every result; plain tasks drive the input stream and an always block the result side.

// Scoreboard: keeps its own copy of the sample store and predicts one result
// for every accepted command item.
class range_average_scoreboard;
  bit [15:0]   wl_store[plra_pkg::PLRA_MAX_SAMPLES];
  longint      lv_store[plra_pkg::PLRA_MAX_SAMPLES];
  int unsigned count;
  bit          order_ok;
  logic [31:0] avg_q[$];
  logic [2:0]  status_q[$];
  int          errors;

  function new();
    count    = 0;
    order_ok = 1'b1;
    errors   = 0;
  endfunction

  function int pending();
    return avg_q.size();
  endfunction

  // Division rounding toward minus infinity.
  function longint floor_div(longint a, longint b);
    longint q;
    if (b <= 0) return 0;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Level of segment seg at wavelength w; a zero-width segment keeps its start level.
  function longint level_at(int seg, longint w);
    longint l0, l1;
    l0 = wl_store[seg];
    l1 = wl_store[seg + 1];
    if (l1 <= l0) return lv_store[seg];
    return lv_store[seg] + floor_div((lv_store[seg + 1] - lv_store[seg]) * (w - l0), l1 - l0);
  endfunction

  // Mean of the curve over [s, e], before saturation.
  function longint span_mean(longint s, longint e, output logic [2:0] st);
    int     n, i;
    longint first, last, sum, a, b, li, lj;
    n     = count;
    i     = 0;
    first = wl_store[0];
    last  = wl_store[n - 1];
    sum   = 0;
    st    = plra_pkg::ST_OK;
    if (e <= first) return lv_store[0];
    if (s >= last) return lv_store[n - 1];
    if (n == 1) return lv_store[0];
    if (e <= s) begin
      st = plra_pkg::ST_ZERO_WIDTH;
      return 0;
    end
    // Flat tails outside the stored curve.
    if (s < first) sum += 2 * lv_store[0] * (first - s);
    if (e > last) sum += 2 * lv_store[n - 1] * (e - last);
    while (i + 2 < n && s > wl_store[i + 1]) i++;
    for (; i + 1 < n && e >= wl_store[i]; i++) begin
      li = wl_store[i];
      lj = wl_store[i + 1];
      a  = (s > li) ? s : li;
      b  = (e < lj) ? e : lj;
      if (b <= a) continue;
      sum += (level_at(i, a) + level_at(i, b)) * (b - a);
    end
    return floor_div(sum + (e - s), 2 * (e - s));
  endfunction

  function void note_item(logic [1:0] cmd, logic [79:0] data);
    logic [2:0] st;
    longint     avg;
    st  = plra_pkg::ST_OK;
    avg = 0;
    case (cmd)
      plra_pkg::CMD_CLEAR: begin
        count    = 0;
        order_ok = 1'b1;
      end
      plra_pkg::CMD_APPEND: begin
        if (count >= plra_pkg::PLRA_MAX_SAMPLES) begin
          st = plra_pkg::ST_FULL;
        end else begin
          if (count > 0 && data[15:0] < wl_store[count - 1]) order_ok = 1'b0;
          wl_store[count] = data[15:0];
          lv_store[count] = longint'($signed(data[47:16]));
          count++;
        end
      end
      plra_pkg::CMD_QUERY: begin
        if (count == 0) begin
          st = plra_pkg::ST_NO_SAMPLES;
        end else if (!order_ok) begin
          st = plra_pkg::ST_UNSORTED;
        end else begin
          avg = span_mean(longint'(data[63:48]), longint'(data[79:64]), st);
          if (avg > 64'sd2147483647) avg = 64'sd2147483647;
          if (avg < -64'sd2147483648) avg = -64'sd2147483648;
        end
      end
      default: ;  // The unused selector changes nothing.
    endcase
    avg_q.push_back(avg[31:0]);
    status_q.push_back(st);
  endfunction

  function void check_result(logic [31:0] avg, logic [2:0] st);
    logic [31:0] exp_avg;
    logic [2:0]  exp_st;
    if (avg_q.size() == 0) begin
      $error("unexpected result: average %0h status %0d", avg, st);
      errors++;
      return;
    end
    exp_avg = avg_q.pop_front();
    exp_st  = status_q.pop_front();
    if (avg !== exp_avg) begin
      $error("average: expected %0h actual %0h", exp_avg, avg);
      errors++;
    end
    if (st !== exp_st) begin
      $error("status: expected %0d actual %0d", exp_st, st);
      errors++;
    end
  endfunction
endclass

module tb_piecewise_linear_range_average;
  import plra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The block also accepts selector 3 as a no-operation command.
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_GOAL   = 650;
  // The random curves stop early enough to leave room for the final store fill.
  localparam int RANDOM_GOAL = ITEM_GOAL - 70;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  range_average_scoreboard sb = new();
  int items_sent = 0;
  bit no_idle = 1'b0;     // Set for the last part of the run: no gaps, no stalls.
  int stall_left = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  piecewise_linear_range_average dut (.*);

  // Sends one item. An optional burst of idle cycles comes first; valid stays
  // high between back-to-back items so it is never lowered and raised in one step.
  task automatic send_item(logic [1:0] cmd, logic [15:0] wl, logic [31:0] lv,
                           logic [15:0] rs, logic [15:0] re);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {re, rs, lv, wl};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, {re, rs, lv, wl});
    items_sent++;
  endtask

  task automatic append(logic [15:0] wl, logic [31:0] lv);
    send_item(CMD_APPEND, wl, lv, $urandom, $urandom);
  endtask

  task automatic query(logic [15:0] rs, logic [15:0] re);
    send_item(CMD_QUERY, $urandom, $urandom, rs, re);
  endtask

  // One random curve: a clear, a run of appends and a few queries.
  // Most curves are sorted; a few carry one out-of-order pair or overfill the store.
  task automatic random_curve();
    logic [15:0] wls[70];
    logic [15:0] tmp, lo, span, rs, re;
    logic [31:0] lv;
    int n, pick, j, k;
    pick = $urandom_range(0, 99);
    if (pick < 80) n = $urandom_range(1, 10);
    else if (pick < 92) n = $urandom_range(11, 40);
    else n = $urandom_range(62, 66);
    // Narrow curves make ranges land on segments; wide ones exercise all bits.
    span = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'($urandom_range(4, 600));
    lo   = $urandom;
    if (32'(lo) + 32'(span) > 65535) lo = 16'hffff - span;
    for (j = 0; j < n; j++) begin
      if (j > 0 && $urandom_range(0, 7) == 0) wls[j] = wls[j - 1];  // zero-width segment
      else wls[j] = lo + 16'($urandom_range(0, span));
    end
    for (j = 1; j < n; j++)
      for (k = j; k > 0 && wls[k] < wls[k - 1]; k--) begin
        tmp = wls[k]; wls[k] = wls[k - 1]; wls[k - 1] = tmp;
      end
    if (n > 1 && $urandom_range(0, 9) == 0) begin
      j = $urandom_range(1, n - 1);
      if (wls[j] != wls[j - 1]) begin
        tmp = wls[j]; wls[j] = wls[j - 1]; wls[j - 1] = tmp;
      end
    end
    send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 3))
        0: lv = $urandom;
        1: lv = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
        2: lv = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        default: lv = 32'($urandom_range(0, 65535 * 4));
      endcase
      append(wls[j], lv);
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: begin rs = $urandom; re = $urandom; end
        1: begin rs = $urandom; re = rs; end
        2: begin re = $urandom; rs = re + 16'($urandom_range(1, 100)); end
        default: begin
          rs = lo + 16'($urandom_range(0, span)) - 16'($urandom_range(0, 20));
          re = rs + 16'($urandom_range(1, span));
        end
      endcase
      if ($urandom_range(0, 15) == 0) send_item(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
      query(rs, re);
    end
  endtask

  // Result side: check every accepted result and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (no_idle || $urandom_range(0, 5) != 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_piecewise_linear_range_average NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty store, single sample, extremes and every special case but the full store.
    query(16'd10, 16'd20);                       // no samples
    send_item(CMD_NOP, 16'hffff, 32'hffffffff, 16'hffff, 16'hffff);
    append(16'd100, 32'h7fffffff);
    query(16'd0, 16'd50);                        // single sample
    query(16'd20, 16'd10);                       // range below the sample wins over reversed range
    append(16'd100, 32'h80000000);               // zero-width segment
    append(16'd300, 32'h00010000);
    append(16'hffff, 32'hffff0000);
    query(16'd0, 16'd100);                       // range below the curve
    query(16'hffff, 16'hffff);                   // range above the curve
    query(16'd0, 16'hffff);                      // lower tail and every segment
    query(16'd150, 16'd150);                     // zero-width range
    query(16'd250, 16'd200);                     // reversed range
    query(16'd120, 16'd280);                     // inside one segment
    append(16'd5, 32'd0);                        // out of order
    query(16'd0, 16'd10);                        // unsorted store
    send_item(CMD_CLEAR, 16'hffff, 32'hffffffff, 16'hffff, 16'hffff);
    query(16'd0, 16'd10);                        // cleared store
    append(16'd0, 32'h80000000);
    append(16'd1, 32'h80000000);
    query(16'd0, 16'd1);                         // result at the negative limit

    // Random part: curves with queries; the last stretch runs without idling.
    while (items_sent < RANDOM_GOAL) begin
      if (items_sent > RANDOM_GOAL * 7 / 8) no_idle = 1'b1;
      random_curve();
    end
    // Fill the store to the top and push one past it.
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    for (int j = 0; j <= PLRA_MAX_SAMPLES; j++) append(16'(j * 1000), $urandom);
    query(16'd500, 16'd62500);
    in_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_piecewise_linear_range_average OK");
    end else begin
      $display("tb_piecewise_linear_range_average NOT OK");
    end
    $finish;
  end
endmodule
